@@ sv/irsw_pkg.sv @@
// Package for the interlaced row shift wipe block.
// Holds the frame geometry, the fixed-point widths and the sideband type.
// No dependencies.
`default_nettype none

package irsw_pkg;

    // Frame geometry.
    localparam int LINE_WIDTH   = 640;
    localparam int FRAME_HEIGHT = 480;

    // Field widths.
    localparam int COL_W = 10;
    localparam int ROW_W = 9;
    localparam int PRG_W = 13;
    localparam int ROFS_W = 12;

    // Fixed-point constants.
    localparam int ONE_Q12 = 4096;
    localparam int ONE_Q16 = 65536;
    localparam int Q16_SH  = 16;
    localparam int P_SH    = 28;

    // Divider: u = (FRAME_HEIGHT << 16) / (row + FRAME_HEIGHT), never above 2^16.
    localparam int U_W   = Q16_SH + 1;
    localparam int DEN_W = $clog2(FRAME_HEIGHT + (1 << ROW_W));
    localparam int REM_W = DEN_W + U_W;
    localparam logic [REM_W-1:0] NUMER = REM_W'(FRAME_HEIGHT) << Q16_SH;

    // f = 4*u2 - 4*u - 1.0 stays within -2.0 .. -1.0, so its magnitude fits 18 bits.
    localparam int F_W   = U_W + 4;
    localparam int FM_W  = U_W + 1;
    localparam int W_W   = $clog2(LINE_WIDTH + 1);
    localparam int FR_W  = FM_W + PRG_W;
    localparam int P_W   = FR_W + W_W;
    localparam int MAG_W = P_W - P_SH;
    localparam int OFF_W = MAG_W + 1;
    localparam int SX_W  = ((OFF_W > COL_W + 1) ? OFF_W : COL_W + 1) + 1;

    // Saturation limits of the reported row offset.
    localparam int SAT_HI = (1 << (ROFS_W - 1)) - 1;
    localparam int SAT_LO = -(1 << (ROFS_W - 1));

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } t_side;

endpackage

`default_nettype wire

@@ sv/irsw_div.sv @@
// Pipelined restoring divider for the per-row factor u in Q16.
// One quotient bit per stage; the pixel position rides along as sideband.
// Depends on irsw_pkg.
`default_nettype none

module irsw_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire irsw_pkg::t_side            i_side,
    output logic                            o_vld,
    output logic [irsw_pkg::U_W-1:0]        o_u,
    output irsw_pkg::t_side                 o_side
);
    import irsw_pkg::*;

    logic [U_W-1:0]   r_vld;
    logic [REM_W-1:0] r_rem  [U_W-1];
    logic [DEN_W-1:0] r_den  [U_W-1];
    logic [U_W-1:0]   r_quo  [U_W];
    t_side            r_side [U_W];

    logic [REM_W-1:0] c_rem  [U_W];
    logic [DEN_W-1:0] c_den  [U_W];
    logic [U_W-1:0]   c_quo  [U_W];
    t_side            c_side [U_W];
    logic [REM_W-1:0] c_dsh  [U_W];
    logic [U_W-1:0]   c_take;

    logic [REM_W-1:0] n_rem  [U_W-1];
    logic [U_W-1:0]   n_quo  [U_W];

    // Stage inputs: the first stage starts from the fixed dividend.
    assign c_rem[0]  = NUMER;
    assign c_den[0]  = DEN_W'(i_side.row) + DEN_W'(FRAME_HEIGHT);
    assign c_quo[0]  = '0;
    assign c_side[0] = i_side;

    for (genvar k = 1; k < U_W; k++) begin : g_link
        assign c_rem[k]  = r_rem[k-1];
        assign c_den[k]  = r_den[k-1];
        assign c_quo[k]  = r_quo[k-1];
        assign c_side[k] = r_side[k-1];
    end

    always_comb begin
        for (int k = 0; k < U_W; k++) begin
            c_dsh[k]  = REM_W'(c_den[k]) << (U_W - 1 - k);
            c_take[k] = (c_rem[k] >= c_dsh[k]);
            n_quo[k]  = c_quo[k];
            n_quo[k][U_W-1-k] = c_take[k];
        end
        for (int k = 0; k < U_W - 1; k++) begin
            n_rem[k] = c_take[k] ? (c_rem[k] - c_dsh[k]) : c_rem[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[U_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < U_W; k++) begin
                r_quo[k]  <= n_quo[k];
                r_side[k] <= c_side[k];
            end
            for (int k = 0; k < U_W - 1; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= c_den[k];
            end
        end
    end

    assign o_vld  = r_vld[U_W-1];
    assign o_u    = r_quo[U_W-1];
    assign o_side = r_side[U_W-1];

endmodule

`default_nettype wire

@@ sv/irsw_ofs.sv @@
// Row offset and source column pipeline: square, shape polynomial,
// progress scaling, line width scaling, sign, range test and saturation.
// Depends on irsw_pkg.
`default_nettype none

module irsw_ofs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic [irsw_pkg::U_W-1:0]      i_u,
    input  wire irsw_pkg::t_side               i_side,
    input  wire logic [irsw_pkg::PRG_W-1:0]    i_progress,
    output logic                               o_vld,
    output logic [irsw_pkg::COL_W-1:0]         o_source_column,
    output logic                               o_in_range,
    output logic signed [irsw_pkg::ROFS_W-1:0] o_row_offset
);
    import irsw_pkg::*;

    logic [5:0] r_vld;

    // Stage a: u and u^2 in Q16.
    logic [2*U_W-1:0] n_sq;
    logic [U_W-1:0]   r_a_u;
    logic [U_W-1:0]   r_a_u2;
    t_side            r_a_side;

    // Stage b: magnitude of f and the combined sign of the offset.
    logic [F_W-1:0]   n_f;
    logic [FM_W-1:0]  n_fmag;
    logic [FM_W-1:0]  r_b_fmag;
    logic             r_b_neg;
    logic [COL_W-1:0] r_b_col;

    // Stage c: |f| * remaining progress.
    logic [PRG_W-1:0] n_rem;
    logic [FR_W-1:0]  r_c_fr;
    logic             r_c_neg;
    logic [COL_W-1:0] r_c_col;

    // Stage d: scaled by the line width.
    logic [P_W-1:0]   r_d_pm;
    logic             r_d_neg;
    logic [COL_W-1:0] r_d_col;

    // Stage e: signed offset, truncated toward zero.
    logic [MAG_W-1:0] n_mag;
    logic [OFF_W-1:0] r_e_off;
    logic [COL_W-1:0] r_e_col;

    // Stage f: results.
    logic [SX_W-1:0]   n_offx;
    logic [SX_W-1:0]   n_sx;
    logic              n_ok;
    logic [ROFS_W-1:0] n_shown;
    logic [COL_W-1:0]  r_f_src;
    logic              r_f_ok;
    logic [ROFS_W-1:0] r_f_ofs;

    assign n_sq = (2*U_W)'(i_u) * (2*U_W)'(i_u);

    assign n_f    = (F_W'(r_a_u2) << 2) - (F_W'(r_a_u) << 2) - F_W'(ONE_Q16);
    assign n_fmag = n_f[F_W-1] ? FM_W'(F_W'(0) - n_f) : FM_W'(n_f);

    assign n_rem = (i_progress > PRG_W'(ONE_Q12)) ? '0 : (PRG_W'(ONE_Q12) - i_progress);

    assign n_mag = r_d_pm[P_W-1:P_SH];

    // Everything below runs in SX_W bits, wide enough for the exact source column.
    assign n_offx = {{(SX_W-OFF_W){r_e_off[OFF_W-1]}}, r_e_off};
    assign n_sx   = SX_W'(r_e_col) - n_offx;
    assign n_ok   = !n_sx[SX_W-1] && (n_sx < SX_W'(LINE_WIDTH));

    always_comb begin
        if ($signed(n_offx) > $signed(SX_W'(SAT_HI))) begin
            n_shown = ROFS_W'(SAT_HI);
        end else if ($signed(n_offx) < $signed(SX_W'(SAT_LO))) begin
            n_shown = ROFS_W'(SAT_LO);
        end else begin
            n_shown = n_offx[ROFS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_u    <= i_u;
            r_a_u2   <= n_sq[Q16_SH+U_W-1:Q16_SH];
            r_a_side <= i_side;

            r_b_fmag <= n_fmag;
            r_b_neg  <= n_f[F_W-1] ^ r_a_side.row[0];
            r_b_col  <= r_a_side.column;

            r_c_fr   <= FR_W'(r_b_fmag) * FR_W'(n_rem);
            r_c_neg  <= r_b_neg;
            r_c_col  <= r_b_col;

            r_d_pm   <= P_W'(r_c_fr) * P_W'(LINE_WIDTH);
            r_d_neg  <= r_c_neg;
            r_d_col  <= r_c_col;

            r_e_off  <= r_d_neg ? (OFF_W'(0) - OFF_W'(n_mag)) : OFF_W'(n_mag);
            r_e_col  <= r_d_col;

            r_f_src  <= n_ok ? n_sx[COL_W-1:0] : '0;
            r_f_ok   <= n_ok;
            r_f_ofs  <= n_shown;
        end
    end

    assign o_vld           = r_vld[5];
    assign o_source_column = r_f_src;
    assign o_in_range      = r_f_ok;
    assign o_row_offset    = $signed(r_f_ofs);

endmodule

`default_nettype wire

@@ sv/interlaced_row_shift_wipe_core.sv @@
// Interlaced row shift wipe: source column finder for one destination pixel.
// An accepted transaction passes through 17 divider stages, one quotient bit each,
// then 6 arithmetic stages before its result is presented.
// Throughput is one transaction per cycle; the whole pipeline holds while a result waits.
// Synchronous active-low reset clears all valid bits and sets progress to zero.
`default_nettype none

module interlaced_row_shift_wipe_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [irsw_pkg::PRG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [irsw_pkg::COL_W-1:0]    i_column,
    input  wire logic [irsw_pkg::ROW_W-1:0]    i_row,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [irsw_pkg::COL_W-1:0]         o_source_column,
    output logic                               o_in_range,
    output logic signed [irsw_pkg::ROFS_W-1:0] o_row_offset
);
    import irsw_pkg::*;

    logic [PRG_W-1:0] r_progress;
    logic             en;
    t_side            in_side;
    logic             div_vld;
    logic [U_W-1:0]   div_u;
    t_side            div_side;

    // The pipeline advances whenever the last stage is empty or being drained.
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign in_side.column = i_column;
    assign in_side.row    = i_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_progress <= '0;
        end else if (i_cfg_we) begin
            r_progress <= i_cfg_data;
        end
    end

    irsw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid),
        .i_side  (in_side),
        .o_vld   (div_vld),
        .o_u     (div_u),
        .o_side  (div_side)
    );

    irsw_ofs u_ofs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_vld           (div_vld),
        .i_u             (div_u),
        .i_side          (div_side),
        .i_progress      (r_progress),
        .o_vld           (o_out_valid),
        .o_source_column (o_source_column),
        .o_in_range      (o_in_range),
        .o_row_offset    (o_row_offset)
    );

endmodule

`default_nettype wire

@@ tb/irsw_wipe_checker.sv @@
// Checker for the interlaced row shift wipe core: predicts each source column and compares.
// Watches the progress writes and both channels, keeps its own progress copy.
// Depends on irsw_pkg for geometry, widths and fixed-point constants.
module irsw_wipe_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [irsw_pkg::PRG_W-1:0]         i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_ready,
    input  wire logic [irsw_pkg::COL_W-1:0]         i_column,
    input  wire logic [irsw_pkg::ROW_W-1:0]         i_row,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic [irsw_pkg::COL_W-1:0]         i_source_column,
    input  wire logic                               i_in_range,
    input  wire logic signed [irsw_pkg::ROFS_W-1:0] i_row_offset,
    output int                                      o_fail_count,
    output int                                      o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import irsw_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0]         source_column;
        logic                     in_range;
        logic signed [ROFS_W-1:0] row_offset;
    } t_wipe_pixel;

    t_wipe_pixel        wipe_pixels_q[$];
    logic [PRG_W-1:0]   progress_copy = '0;
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    // Source column and row shift for one destination pixel at the given progress.
    function automatic t_wipe_pixel wipe_source(input logic [COL_W-1:0] col,
                                                input logic [ROW_W-1:0] r,
                                                input logic [PRG_W-1:0] prog);
        longint unsigned u_q16;
        longint unsigned u_sq;
        longint          f_q16;
        longint          clamp;
        longint          remain;
        longint          prod;
        longint          shift;
        longint          shown;
        longint          sx;
        logic            ok;
        t_wipe_pixel     res;
        u_q16 = (64'(FRAME_HEIGHT) << Q16_SH) / (64'(r) + 64'(FRAME_HEIGHT));
        u_sq  = (u_q16 * u_q16) >> Q16_SH;
        f_q16 = 4 * $signed(u_sq) - 4 * $signed(u_q16) - ONE_Q16;
        if (prog > PRG_W'(ONE_Q12)) begin
            clamp = ONE_Q12;
        end else begin
            clamp = longint'(prog);
        end
        remain = ONE_Q12 - clamp;
        prod   = f_q16 * remain * LINE_WIDTH;
        // Truncate toward zero, so shift the magnitude.
        if (prod < 0) begin
            shift = -((-prod) >> P_SH);
        end else begin
            shift = prod >> P_SH;
        end
        if (r[0]) begin
            shift = -shift;
        end
        sx = longint'(col) - shift;
        ok = (sx >= 0) && (sx < LINE_WIDTH);
        shown = shift;
        if (shown > SAT_HI) begin
            shown = SAT_HI;
        end
        if (shown < SAT_LO) begin
            shown = SAT_LO;
        end
        res.source_column = ok ? sx[COL_W-1:0] : '0;
        res.in_range      = ok;
        res.row_offset    = shown[ROFS_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_wipe_pixel want;
        if (!i_rst_n) begin
            wipe_pixels_q.delete();
            progress_copy <= '0;
            o_pending     <= 0;
        end else begin
            if (i_cfg_we) begin
                progress_copy <= i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (wipe_pixels_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: unexpected result col=%0d range=%0b ofs=%0d",
                                 $realtime, i_source_column, i_in_range, i_row_offset);
                    end
                    fail_count++;
                end else begin
                    want = wipe_pixels_q.pop_front();
                    if (want.source_column !== i_source_column || want.in_range !== i_in_range
                        || want.row_offset !== i_row_offset) begin
                        if (fail_count < 10) begin
                            $display({"%0t: mismatch expected col=%0d range=%0b ofs=%0d,",
                                      " got col=%0d range=%0b ofs=%0d"},
                                     $realtime, want.source_column, want.in_range,
                                     want.row_offset, i_source_column, i_in_range,
                                     i_row_offset);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                wipe_pixels_q.push_back(wipe_source(i_column, i_row, progress_copy));
            end
            o_pending <= wipe_pixels_q.size();
        end
    end

endmodule

@@ tb/tb_interlaced_row_shift_wipe_core.sv @@
// Top of the interlaced row shift wipe testbench: clock, reset, pixel stimulus and verdict.
// Depends on irsw_pkg, interlaced_row_shift_wipe_core and irsw_wipe_checker.
module tb_interlaced_row_shift_wipe_core;

    timeunit 1ns;
    timeprecision 1ps;

    import irsw_pkg::*;

    localparam int PIPE_DEPTH = 23;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [PRG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [COL_W-1:0]          column = '0;
    logic [ROW_W-1:0]          row = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [COL_W-1:0]          source_column;
    logic                      in_range;
    logic signed [ROFS_W-1:0]  row_offset;
    int                        fail_count;
    int                        pending;
    int                        burst_left = 0;
    int                        stall_cycle = 0;

    interlaced_row_shift_wipe_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_column        (column),
        .i_row           (row),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_source_column (source_column),
        .o_in_range      (in_range),
        .o_row_offset    (row_offset)
    );

    irsw_wipe_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_column        (column),
        .i_row           (row),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_source_column (source_column),
        .i_in_range      (in_range),
        .i_row_offset    (row_offset),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The receiver cycles through four stall behaviors, chosen in turn from a free-running cycle counter.
    always @(posedge clk) begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 256) % 4)
            0: begin
                out_ready <= 1'b1;
            end
            1: begin
                out_ready <= $urandom_range(0, 1);
            end
            2: begin
                out_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                out_ready <= ((stall_cycle % 7) >= 3);
            end
        endcase
    end

    // Offers one pixel and returns at the edge where the transaction is taken.
    task automatic send_pixel(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        column   <= c;
        row      <= r;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drains every pending result before the progress register changes.
    task automatic write_progress(input logic [PRG_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        burst_left = 0;
    endtask

    initial begin
        logic [PRG_W-1:0] phase_progress[7];
        logic [PRG_W-1:0] prog;
        logic [COL_W-1:0] c;
        logic [ROW_W-1:0] r;
        phase_progress = '{13'd4096, 13'd0, 13'd8191, 13'd1, 13'd4095, 13'd2048, 13'd4097};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full shift: largest offsets, edges of the line and rows beyond the frame.
        write_progress(13'd0);
        send_pixel(10'd0, 9'd0);
        send_pixel(10'd639, 9'd0);
        send_pixel(10'd0, 9'd1);
        send_pixel(10'd639, 9'd1);
        send_pixel(10'd1023, 9'd0);
        send_pixel(10'd0, 9'd511);
        send_pixel(10'd1023, 9'd511);
        send_pixel(10'd320, 9'd479);
        send_pixel(10'd320, 9'd480);
        send_pixel(10'd5, 9'd2);
        send_pixel(10'd600, 9'd3);
        send_pixel(10'd511, 9'd256);
        send_pixel(10'd512, 9'd255);
        // Done: zero offset, so only columns past the line go black.
        write_progress(13'd4096);
        send_pixel(10'd639, 9'd0);
        send_pixel(10'd640, 9'd1);
        send_pixel(10'd1023, 9'd2);
        send_pixel(10'd0, 9'd0);
        // Progress above one saturates.
        write_progress(13'd8191);
        send_pixel(10'd700, 9'd5);
        send_pixel(10'd100, 9'd100);

        for (int phase = 0; phase < 10; phase++) begin
            prog = (phase < 7) ? phase_progress[phase] : PRG_W'($urandom_range(0, 8191));
            write_progress(prog);
            for (int n = 0; n < 100; n++) begin
                c = ($urandom_range(0, 4) != 0) ? COL_W'($urandom_range(0, LINE_WIDTH - 1))
                                                : COL_W'($urandom_range(0, 1023));
                r = ($urandom_range(0, 4) != 0) ? ROW_W'($urandom_range(0, FRAME_HEIGHT - 1))
                                                : ROW_W'($urandom_range(0, 511));
                send_pixel(c, r);
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (PIPE_DEPTH + 7) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/irsw_pkg.sv
sv/irsw_div.sv
sv/irsw_ofs.sv
sv/interlaced_row_shift_wipe_core.sv
tb/irsw_wipe_checker.sv
tb/tb_interlaced_row_shift_wipe_core.sv
